// ----- rtl/core/qpr_pkg.sv -----
// shared types and register codes of the quaternion point rotator
package qpr_pkg;

  // configuration register index width and codes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_QUAT_W = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_QUAT_X = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_QUAT_Y = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_QUAT_Z = 2'd3;

  // per stage advance enables of the multiply-add pipeline
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic sum_en;
    logic out_en;
  } stage_en_t;

endpackage

// ----- rtl/core/quaternion_point_rotator_unit.sv -----
// quaternion point rotator: one beat per cycle while the output is not stalled
// an accepted point passes the capture, alignment, multiply, combine, sum and output registers before it is offered
// the six stage multiply-add pipeline advances every cycle in which the output is not stalled
// a quaternion write reaches the matrix through the product and matrix registers, before any following point uses it
// synchronous active-low reset empties the pipeline and loads the unit quaternion (identity)
module quaternion_point_rotator_unit import qpr_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int QUAT_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [QUAT_WIDTH-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_x_in,
  input  logic signed [COORD_WIDTH-1:0] in_y_in,
  input  logic signed [COORD_WIDTH-1:0] in_z_in,
  input  logic                          in_last_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x_out,
  output logic signed [COORD_WIDTH-1:0] out_y_out,
  output logic signed [COORD_WIDTH-1:0] out_z_out,
  output logic                          out_last_out
);

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = 2 * QUAT_WIDTH + 4;
  localparam int FRAC = 2 * (QUAT_WIDTH - 2);

  logic signed [MW-1:0] mat [9];
  logic signed [MW-1:0] row_mat [3][3];
  logic signed [CW-1:0] pt1_r [3];
  logic signed [CW-1:0] pt2_r [3];
  logic signed [CW-1:0] coord [3];
  logic                 last1_r, last2_r, last3_r, last4_r, last5_r, last6_r;
  logic                 v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic                 en1, en2, en3, en4, en5, en6;
  logic                 in_fire, out_fire;
  stage_en_t            stage_en;

  // matrix builder
  qpr_matrix #(
    .QUAT_WIDTH (QUAT_WIDTH),
    .MAT_WIDTH  (MW)
  ) u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mat_o     (mat)
  );

  // stage advance: a stage moves when empty or when the next one moves
  assign en6 = !v6_r || out_ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ready = en1 && rst_n;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = v6_r && out_ready;

  assign stage_en.mul_en = en3;
  assign stage_en.add_en = en4;
  assign stage_en.sum_en = en5;
  assign stage_en.out_en = en6;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_fire;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // input beat capture and alignment stage ahead of the multipliers
  always_ff @(posedge clk) begin
    if (en1) begin
      pt1_r[0] <= in_x_in;
      pt1_r[1] <= in_y_in;
      pt1_r[2] <= in_z_in;
      last1_r  <= in_last_in;
    end
    if (en2) begin
      pt2_r   <= pt1_r;
      last2_r <= last1_r;
    end
  end

  // last flag rides alongside the row pipelines
  always_ff @(posedge clk) begin
    if (en3) last3_r <= last2_r;
    if (en4) last4_r <= last3_r;
    if (en5) last5_r <= last4_r;
    if (en6) last6_r <= last5_r;
  end

  // one multiply-add row per output coordinate
  for (genvar r = 0; r < 3; r++) begin : g_row
    assign row_mat[r][0] = mat[3*r];
    assign row_mat[r][1] = mat[3*r+1];
    assign row_mat[r][2] = mat[3*r+2];

    qpr_row #(
      .COORD_WIDTH (CW),
      .MAT_WIDTH   (MW),
      .MAT_FRAC    (FRAC)
    ) u_row (
      .clk      (clk),
      .stage_en (stage_en),
      .pt_i     (pt2_r),
      .mat_i    (row_mat[r]),
      .coord_o  (coord[r])
    );
  end

  assign out_valid    = v6_r;
  assign out_x_out    = coord[0];
  assign out_y_out    = coord[1];
  assign out_z_out    = coord[2];
  assign out_last_out = last6_r;

  // beats in flight change only by accepted input and delivered output
  a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones({v1_r, v2_r, v3_r, v4_r, v5_r, v6_r}) ==
      $past($countones({v1_r, v2_r, v3_r, v4_r, v5_r, v6_r})) +
      $past(int'(in_fire)) - $past(int'(out_fire))))
    else $error("pipeline lost or duplicated a beat");

  // a full pipeline with a stalled output takes no new beat
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && v5_r && v6_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline full and stalled");

  // an accepted beat lands in the first stage
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v1_r)
    else $error("accepted beat not captured");

endmodule

// ----- rtl/core/qpr_matrix.sv -----
// quaternion registers and two stage rotation matrix builder
module qpr_matrix import qpr_pkg::*; #(
  parameter int QUAT_WIDTH = 16,
  parameter int MAT_WIDTH  = 36
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [QUAT_WIDTH-1:0]         cfg_wdata,
  output logic signed [MAT_WIDTH-1:0]   mat_o [9]
);

  localparam int QW   = QUAT_WIDTH;
  localparam int MW   = MAT_WIDTH;
  localparam int FRAC = 2 * (QW - 2);

  logic signed [QW-1:0]   quat_w_r, quat_x_r, quat_y_r, quat_z_r;
  logic signed [2*QW-1:0] aa_r, bb_r, cc_r, dd_r;
  logic signed [2*QW-1:0] ab_r, ac_r, ad_r, bc_r, bd_r, cd_r;
  logic signed [MW-1:0]   mat_nxt [9];
  logic signed [MW-1:0]   mat_r [9];

  // quaternion registers, reset to the unit quaternion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_w_r <= {2'b01, {(QW-2){1'b0}}};
      quat_x_r <= '0;
      quat_y_r <= '0;
      quat_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_QUAT_W: quat_w_r <= cfg_wdata;
        REG_QUAT_X: quat_x_r <= cfg_wdata;
        REG_QUAT_Y: quat_y_r <= cfg_wdata;
        REG_QUAT_Z: quat_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage one: the ten pairwise products
  always_ff @(posedge clk) begin
    aa_r <= quat_w_r * quat_w_r;
    bb_r <= quat_x_r * quat_x_r;
    cc_r <= quat_y_r * quat_y_r;
    dd_r <= quat_z_r * quat_z_r;
    ab_r <= quat_w_r * quat_x_r;
    ac_r <= quat_w_r * quat_y_r;
    ad_r <= quat_w_r * quat_z_r;
    bc_r <= quat_x_r * quat_y_r;
    bd_r <= quat_x_r * quat_z_r;
    cd_r <= quat_y_r * quat_z_r;
  end

  // stage two: matrix entries from the standard formulas
  always_comb begin
    mat_nxt[0] = MW'(aa_r) + MW'(bb_r) - MW'(cc_r) - MW'(dd_r);
    mat_nxt[1] = (MW'(bc_r) - MW'(ad_r)) <<< 1;
    mat_nxt[2] = (MW'(bd_r) + MW'(ac_r)) <<< 1;
    mat_nxt[3] = (MW'(bc_r) + MW'(ad_r)) <<< 1;
    mat_nxt[4] = MW'(aa_r) - MW'(bb_r) + MW'(cc_r) - MW'(dd_r);
    mat_nxt[5] = (MW'(cd_r) - MW'(ab_r)) <<< 1;
    mat_nxt[6] = (MW'(bd_r) - MW'(ac_r)) <<< 1;
    mat_nxt[7] = (MW'(cd_r) + MW'(ab_r)) <<< 1;
    mat_nxt[8] = MW'(aa_r) - MW'(bb_r) - MW'(cc_r) + MW'(dd_r);
  end

  always_ff @(posedge clk) begin
    mat_r <= mat_nxt;
  end

  assign mat_o = mat_r;

  localparam logic signed [MW-1:0] MAT_ONE = {{(MW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

  // the unit quaternion from reset settles to the identity matrix
  a_reset_identity: assert property (@(posedge clk)
    (!rst_n ##1 rst_n) |-> ##2 (mat_r[0] == MAT_ONE && mat_r[4] == MAT_ONE &&
      mat_r[8] == MAT_ONE && mat_r[1] == '0 && mat_r[5] == '0 && mat_r[6] == '0))
    else $error("matrix not identity after reset");

endmodule

// ----- rtl/core/qpr_row.sv -----
// one matrix row times the point: split multiply, combine, sum, round and saturate
module qpr_row import qpr_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int MAT_WIDTH   = 36,
  parameter int MAT_FRAC    = 28
) (
  input  logic                          clk,
  input  stage_en_t                     stage_en,
  input  logic signed [COORD_WIDTH-1:0] pt_i [3],
  input  logic signed [MAT_WIDTH-1:0]   mat_i [3],
  output logic signed [COORD_WIDTH-1:0] coord_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = MAT_WIDTH;
  localparam int LO_W = MW / 2;
  localparam int HI_W = MW - LO_W;
  localparam int PW   = MW + CW;
  localparam int SW   = PW + 2;

  localparam logic signed [SW-1:0] HALF =
    {{(SW-MAT_FRAC){1'b0}}, 1'b1, {(MAT_FRAC-1){1'b0}}};
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [LO_W+CW:0]   lo_nxt [3];
  logic signed [HI_W+CW-1:0] hi_nxt [3];
  logic signed [LO_W+CW:0]   lo_r [3];
  logic signed [HI_W+CW-1:0] hi_r [3];
  logic signed [PW-1:0]      prod_r [3];
  logic signed [SW-1:0]      acc_r;
  logic signed [SW-1:0]      rnd;
  logic signed [SW-1:0]      shf;
  logic signed [CW-1:0]      coord_nxt;
  logic signed [CW-1:0]      coord_r;

  // split each entry into an unsigned low half and a signed high half
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo_nxt[j] = $signed({1'b0, mat_i[j][LO_W-1:0]}) * pt_i[j];
      hi_nxt[j] = $signed(mat_i[j][MW-1:LO_W]) * pt_i[j];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en.mul_en) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  // recombine the halves into full products
  always_ff @(posedge clk) begin
    if (stage_en.add_en) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[j] <= (PW'(hi_r[j]) <<< LO_W) + PW'(lo_r[j]);
      end
    end
  end

  // row sum
  always_ff @(posedge clk) begin
    if (stage_en.sum_en) begin
      acc_r <= SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]);
    end
  end

  // round half up, drop fraction bits, saturate
  always_comb begin
    rnd = acc_r + HALF;
    shf = rnd >>> MAT_FRAC;
    if (shf > SAT_HI) begin
      coord_nxt = SAT_HI[CW-1:0];
    end else if (shf < SAT_LO) begin
      coord_nxt = SAT_LO[CW-1:0];
    end else begin
      coord_nxt = shf[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en.out_en) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord_o = coord_r;

endmodule

// ----- tb/qpr_checker.sv -----
// checker for the quaternion point rotator: predicts rotated points and compares output beats
module qpr_checker import qpr_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int QUAT_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [QUAT_WIDTH-1:0]         cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_x_in,
  input  logic signed [COORD_WIDTH-1:0] in_y_in,
  input  logic signed [COORD_WIDTH-1:0] in_z_in,
  input  logic                          in_last_in,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [COORD_WIDTH-1:0] out_x_out,
  input  logic signed [COORD_WIDTH-1:0] out_y_out,
  input  logic signed [COORD_WIDTH-1:0] out_z_out,
  input  logic                          out_last_out,
  output int                            err_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // matrix entries carry twice the quaternion fraction bits
  localparam int MAT_FRAC = 2 * (QUAT_WIDTH - 2);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          last;
  } point_t;

  // local copy of the quaternion registers
  logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;

  // rotated points still waiting for their output beat
  point_t rotated_q[$];

  // round half up, drop the matrix fraction, clamp to the coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] round_saturate(longint acc);
    longint hi, lo, r;
    hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    r = (acc + (longint'(1) <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[COORD_WIDTH-1:0];
  endfunction

  // unnormalized rotation matrix times the point, all in exact 64-bit math
  function automatic point_t rotate_point(logic signed [COORD_WIDTH-1:0] px,
                                          logic signed [COORD_WIDTH-1:0] py,
                                          logic signed [COORD_WIDTH-1:0] pz,
                                          logic pl);
    longint a, b, c, d, aa, bb, cc, dd;
    longint m [9];
    longint p [3];
    point_t res;
    a = longint'(qw);
    b = longint'(qx);
    c = longint'(qy);
    d = longint'(qz);
    aa = a * a;
    bb = b * b;
    cc = c * c;
    dd = d * d;
    m[0] = aa + bb - cc - dd;
    m[1] = 2 * (b * c - a * d);
    m[2] = 2 * (b * d + a * c);
    m[3] = 2 * (b * c + a * d);
    m[4] = aa - bb + cc - dd;
    m[5] = 2 * (c * d - a * b);
    m[6] = 2 * (b * d - a * c);
    m[7] = 2 * (c * d + a * b);
    m[8] = aa - bb - cc + dd;
    p[0] = longint'(px);
    p[1] = longint'(py);
    p[2] = longint'(pz);
    res.x = round_saturate(m[0] * p[0] + m[1] * p[1] + m[2] * p[2]);
    res.y = round_saturate(m[3] * p[0] + m[4] * p[1] + m[5] * p[2]);
    res.z = round_saturate(m[6] * p[0] + m[7] * p[1] + m[8] * p[2]);
    res.last = pl;
    return res;
  endfunction

  task automatic check_field(string fname, logic signed [COORD_WIDTH-1:0] want_v,
                             logic signed [COORD_WIDTH-1:0] got_v);
    if (got_v !== want_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want_v, got_v);
    end
  endtask

  // track register writes, compare output beats, queue predictions for input beats
  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      qw = {2'b01, {(QUAT_WIDTH-2){1'b0}}};
      qx = '0;
      qy = '0;
      qz = '0;
      rotated_q.delete();
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_QUAT_W: qw = cfg_wdata;
          REG_QUAT_X: qx = cfg_wdata;
          REG_QUAT_Y: qy = cfg_wdata;
          REG_QUAT_Z: qz = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          err_count++;
          $display("%0t: output beat with no point pending, expected none, actual %0d %0d %0d %0b",
                   $time, out_x_out, out_y_out, out_z_out, out_last_out);
        end else begin
          want = rotated_q.pop_front();
          check_field("x_out", want.x, out_x_out);
          check_field("y_out", want.y, out_y_out);
          check_field("z_out", want.z, out_z_out);
          check_field("last_out", COORD_WIDTH'(want.last), COORD_WIDTH'(out_last_out));
        end
      end
      if (in_valid && in_ready)
        rotated_q.push_back(rotate_point(in_x_in, in_y_in, in_z_in, in_last_in));
      pending = rotated_q.size();
    end
  end

endmodule

// ----- tb/quaternion_point_rotator_unit_tb.sv -----
// testbench top for the quaternion point rotator: stimulus, stalls and verdict
module quaternion_point_rotator_unit_tb import qpr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_WIDTH    = 24;
  localparam int QUAT_WIDTH     = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_POINTS   = 75;
  localparam int END_WAIT       = 12;
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = 24'sh7fffff;
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = 24'sh800000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]         cfg_addr = '0;
  logic [QUAT_WIDTH-1:0]         cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [COORD_WIDTH-1:0] in_x_in = '0;
  logic signed [COORD_WIDTH-1:0] in_y_in = '0;
  logic signed [COORD_WIDTH-1:0] in_z_in = '0;
  logic                          in_last_in = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [COORD_WIDTH-1:0] out_x_out;
  logic signed [COORD_WIDTH-1:0] out_y_out;
  logic signed [COORD_WIDTH-1:0] out_z_out;
  logic                          out_last_out;

  int err_count;
  int pending;
  int idle_cycles;
  int points_sent;
  int settings_loaded;
  int stall_left;
  bit idle_on;

  quaternion_point_rotator_unit u_dut (.*);

  qpr_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .QUAT_WIDTH (QUAT_WIDTH)
  ) u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // output stalls in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3: return COORD_WIDTH'($urandom_range(0, 4096) - 2048);
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  // mostly well-scaled quaternion parts, sometimes extremes or raw bits
  function automatic logic signed [QUAT_WIDTH-1:0] rand_quat_part();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3, 4, 5: return QUAT_WIDTH'($urandom_range(0, 16384) - 8192);
      default: return QUAT_WIDTH'($urandom);
    endcase
  endfunction

  // all tasks start and end at a falling edge
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [QUAT_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic load_quat(logic signed [QUAT_WIDTH-1:0] w, logic signed [QUAT_WIDTH-1:0] x,
                           logic signed [QUAT_WIDTH-1:0] y, logic signed [QUAT_WIDTH-1:0] z);
    write_reg(REG_QUAT_W, w);
    write_reg(REG_QUAT_X, x);
    write_reg(REG_QUAT_Y, y);
    write_reg(REG_QUAT_Z, z);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // one input beat, with an optional gap ahead of it
  task automatic send_point(logic signed [COORD_WIDTH-1:0] px, logic signed [COORD_WIDTH-1:0] py,
                            logic signed [COORD_WIDTH-1:0] pz, logic pl);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_x_in <= px;
    in_y_in <= py;
    in_z_in <= pz;
    in_last_in <= pl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
    @(negedge clk);
  endtask

  // stop sending and let every pending point come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // identity after reset: coordinate extremes pass unchanged
    send_point(COORD_MAX, COORD_MIN, 0, 1'b0);
    send_point(COORD_MIN, COORD_MAX, -1, 1'b1);
    send_point(0, 0, 0, 1'b0);
    send_point(1, -1, 1, 1'b1);
    send_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
    drain();

    // most negative scalar: scale by four, saturation at both ends
    load_quat(16'sh8000, 0, 0, 0);
    send_point(COORD_MAX, COORD_MIN, 2097151, 1'b0);
    send_point(2097152, -2097153, -2097152, 1'b1);
    send_point(3, -3, 0, 1'b0);
    drain();

    // scale by a quarter: half-way ties round toward plus infinity
    load_quat(8192, 0, 0, 0);
    send_point(2, -2, 6, 1'b0);
    send_point(-6, 1, -1, 1'b1);
    send_point(COORD_MAX, COORD_MIN, 0, 1'b0);
    drain();

    // quarter turn about z
    load_quat(11585, 0, 0, 11585);
    send_point(1000, 0, 0, 1'b0);
    send_point(0, 1000, -1000, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    drain();

    // unnormalized extremes on every register, then an unnormalized pure vector quaternion
    load_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_point(1, 2, 3, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1, 1'b1);
    drain();
    load_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_point(-1, 0, 1, 1'b1);
    drain();
    load_quat(0, 16384, 16384, 16384);
    send_point(5, -7, 9, 1'b0);
    drain();

    // random quaternions with random point sets, no idling in two phases
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = (ph % 4) != 3;
      load_quat(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part());
      repeat (PHASE_POINTS)
        send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 7) == 0);
      drain();
    end

    repeat (END_WAIT) @(negedge clk);
    $display("rotated %0d points under %0d quaternion settings", points_sent, settings_loaded);
    $display("directed extremes, rounding ties and saturation, then random point sets");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
